FILE: design/mandelbrot_escape_time_4px_assert.svh
// Assertion macros shared by the escape-time engine.
// Depends on nothing; included by the top level only.
`ifndef MANDELBROT_ESCAPE_TIME_4PX_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_4PX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define METS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define METS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mets_pkg.sv
// Shared types, constants and helper functions of the escape-time engine.
// Depends on nothing; used by the lane, the merge stage and the top level.
package mets_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 8;
    localparam int ITER_W = 8;

    localparam logic [ITER_W-1:0] ITER_RESET = 8'd255;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Status of one lane as seen by the merge stage.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_lane_stat;

    // Saturate a 64-bit signed value to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic fits;
        fits = (v[63:WORD_W-1] == {(64-WORD_W+1){1'b0}}) ||
               (v[63:WORD_W-1] == {(64-WORD_W+1){1'b1}});
        if (fits) begin
            return v[WORD_W-1:0];
        end else if (v[63]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

endpackage

FILE: design/mets_lane.sv
// One escape-time lane: iterates z = z^2 + c for a single pixel.
// Depends on mets_pkg (word type helpers and lane status struct).
module mets_lane #(
    parameter int SNAPSHOT_INTERVAL = 16,
    parameter int FRAC_BITS         = 28
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mets_pkg::WORD_W-1:0]  i_cre,
    input  logic signed [mets_pkg::WORD_W-1:0]  i_cim,
    input  logic [mets_pkg::ITER_W-1:0]         i_max_iter,
    output mets_pkg::t_lane_stat                o_stat
);

    localparam int PH_W = $clog2(SNAPSHOT_INTERVAL);
    localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_UPD, L_DONE} t_lstate;

    t_lstate                               r_state;
    logic signed [mets_pkg::WORD_W-1:0]    r_cre, r_cim, r_zr, r_zi, r_snap_r, r_snap_i;
    logic signed [63:0]                    r_pxx, r_pyy, r_pxy;
    logic [PH_W-1:0]                       r_phase;
    logic [mets_pkg::CNT_W-1:0]            r_count, r_result;
    logic [mets_pkg::ITER_W-1:0]           r_left;

    logic signed [mets_pkg::WORD_W-1:0]    w_xx, w_yy, w_xy, w_nzr, w_nzi;
    logic signed [63:0]                    w_mag;
    logic                                  w_escape;

    // Floor shift of each exact product, then saturation to a word.
    always_comb begin
        w_xx     = mets_pkg::sat_word(r_pxx >>> FRAC_BITS);
        w_yy     = mets_pkg::sat_word(r_pyy >>> FRAC_BITS);
        w_xy     = mets_pkg::sat_word(r_pxy >>> FRAC_BITS);
        w_mag    = 64'(w_xx) + 64'(w_yy);
        w_escape = (w_mag >= FOUR);
        w_nzr    = mets_pkg::sat_word(64'(w_xx) - 64'(w_yy) + 64'(r_cre));
        w_nzi    = mets_pkg::sat_word((64'(w_xy) <<< 1) + 64'(r_cim));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else if (i_start) begin
            r_state  <= L_MUL;
            r_cre    <= i_cre;
            r_cim    <= i_cim;
            r_zr     <= '0;
            r_zi     <= '0;
            r_snap_r <= '0;
            r_snap_i <= '0;
            r_phase  <= '0;
            r_count  <= '0;
            r_left   <= i_max_iter;
        end else begin
            unique case (r_state) inside
                L_IDLE, L_DONE: begin
                    r_state <= r_state;
                end
                L_MUL: begin
                    r_pxx   <= 64'(r_zr) * 64'(r_zr);
                    r_pyy   <= 64'(r_zi) * 64'(r_zi);
                    r_pxy   <= 64'(r_zr) * 64'(r_zi);
                    r_state <= L_UPD;
                end
                L_UPD: begin
                    if (w_escape) begin
                        r_result <= r_count;
                        r_state  <= L_DONE;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_zr    <= w_nzr;
                        r_zi    <= w_nzi;
                        r_left  <= r_left - 1'b1;
                        r_state <= L_MUL;
                        if (r_left == mets_pkg::ITER_W'(1)) begin
                            // Limit reached while still bounded: inside the set.
                            r_result <= '0;
                            r_state  <= L_DONE;
                        end else if (r_phase == PH_W'(SNAPSHOT_INTERVAL - 1)) begin
                            r_phase  <= '0;
                            r_snap_r <= w_nzr;
                            r_snap_i <= w_nzi;
                        end else begin
                            r_phase <= r_phase + 1'b1;
                            if (w_nzr == r_snap_r && w_nzi == r_snap_i) begin
                                // Orbit came back to the snapshot: periodic.
                                r_result <= '0;
                                r_state  <= L_DONE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done  = (r_state == L_DONE);
    assign o_stat.count = r_result;

endmodule

FILE: design/mets_merge.sv
// Merge stage: combines the lane status words into one result word.
// Depends on mets_pkg (lane status struct and count width).
module mets_merge #(
    parameter int LANES = 4
) (
    input  mets_pkg::t_lane_stat [LANES-1:0]      i_stat,
    output logic                                 o_all_done,
    output logic                                 o_any_done,
    output logic [LANES*mets_pkg::CNT_W-1:0]     o_data
);

    always_comb begin
        o_all_done = 1'b1;
        o_any_done = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            o_all_done = o_all_done & i_stat[k].done;
            o_any_done = o_any_done | i_stat[k].done;
            o_data[k*mets_pkg::CNT_W +: mets_pkg::CNT_W] = i_stat[k].count;
        end
    end

endmodule

FILE: design/mandelbrot_escape_time_4px.sv
// Top level of the four-pixel escape-time engine: stream ports and lanes.
// Depends on mets_pkg, mets_lane, mets_merge and the assertion header.
//
// Usage. One input word on the slave stream carries a row start x, a row
// coordinate y and a pixel spacing, all signed fixed point. The block works
// out the escape count of LANES adjacent pixels at once, one lane per pixel,
// and sends one output word holding every pixel's 8-bit count, zero for a
// pixel inside the set or caught on a periodic orbit.
// The iteration limit is set through the configuration write port; it is
// meant to be written only while the block is idle.
// Sequence: the lane offsets are formed, the lanes are started, then each
// iteration takes a product step (the three products) and an update step
// until the slowest lane finishes; the result then goes into the output
// register. The rate is set by that iteration loop in each lane; one word is
// in flight at a time, and the next one is taken once its predecessor's
// result sits in the output register.
// A stalled receiver holds the result in the output register; a new word may
// still be accepted and computed, and it waits in the lanes until the output
// register is free. Reset empties the pipeline and sets the limit to 255.
`include "mandelbrot_escape_time_4px_assert.svh"

module mandelbrot_escape_time_4px #(
    parameter int LANES             = 4,
    parameter int SNAPSHOT_INTERVAL = 16,
    parameter int FRAC_BITS         = 28
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: iteration limit (0 acts as 256).
    input  logic                                i_cfg_wr_en,
    input  logic [mets_pkg::ITER_W-1:0]         i_cfg_wr_data,
    // Slave stream. tdata: x_start [31:0], y_coord [63:32], x_step [95:64].
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [3*mets_pkg::WORD_W-1:0]       i_s_axis_tdata,
    // Master stream. tdata: count_px0 [7:0], count_px1 [15:8], and so on,
    // one 8-bit count per lane from lane 0 up.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [LANES*mets_pkg::CNT_W-1:0]    o_m_axis_tdata
);

    localparam int PROD_W = mets_pkg::WORD_W + $clog2(LANES) + 1;

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_START, S_RUN} t_state;

    t_state                                  r_state;
    logic [mets_pkg::ITER_W-1:0]             r_max_iter;
    logic signed [mets_pkg::WORD_W-1:0]      r_x0, r_y, r_step;
    logic signed [PROD_W-1:0]                r_kstep [LANES];
    logic                                    r_out_valid;
    logic [LANES*mets_pkg::CNT_W-1:0]        r_out_data;

    logic signed [mets_pkg::WORD_W-1:0]      w_cre [LANES];
    mets_pkg::t_lane_stat [LANES-1:0]        w_stat;
    logic                                    w_all_done, w_any_done;
    logic [LANES*mets_pkg::CNT_W-1:0]        w_data;
    logic                                    w_in_acc, w_out_free, w_start, w_load;

    assign w_in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_start    = (r_state == S_START);
    // Every lane has finished and the output register can take the result.
    assign w_load     = (r_state == S_RUN) && w_all_done && w_out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= mets_pkg::ITER_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_iter <= i_cfg_wr_data;
        end
    end

    // Pixel real parts: the lane offset is formed exactly, then added to the
    // row start and saturated to a word.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_cre[k] = mets_pkg::sat_word(64'(r_x0) + 64'(r_kstep[k]));
        end
    end

    // Sequencer, input capture and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x0    <= i_s_axis_tdata[0 +: mets_pkg::WORD_W];
                        r_y     <= i_s_axis_tdata[mets_pkg::WORD_W +: mets_pkg::WORD_W];
                        r_step  <= i_s_axis_tdata[2*mets_pkg::WORD_W +: mets_pkg::WORD_W];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int k = 0; k < LANES; k++) begin
                        r_kstep[k] <= PROD_W'(r_step) * $signed(PROD_W'(k));
                    end
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_load) begin
                        r_out_data  <= w_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        mets_lane #(
            .SNAPSHOT_INTERVAL (SNAPSHOT_INTERVAL),
            .FRAC_BITS         (FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_start),
            .i_cre      (w_cre[k]),
            .i_cim      (r_y),
            .i_max_iter (r_max_iter),
            .o_stat     (w_stat[k])
        );
    end

    mets_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_stat     (w_stat),
        .o_all_done (w_all_done),
        .o_any_done (w_any_done),
        .o_data     (w_data)
    );

    // An accepted word always moves on to offset preparation.
    `METS_ASSERT_NEXT(a_acc_to_prep, i_clk, i_rst_n, w_in_acc, r_state == S_PREP,
        "accepted word did not enter preparation")

    // Starting the lanes clears every lane's finished flag.
    `METS_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, w_start, !w_any_done,
        "a lane still reported done after start")

    // A finished set of lanes with a free output register yields a result.
    `METS_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n,
        (r_state == S_RUN) && w_all_done && w_out_free,
        o_m_axis_tvalid && (r_state == S_IDLE),
        "finished result was not loaded into the output register")

endmodule
